// ===== hdl/sorted_list_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted list table assertion macros
// concurrent checks clocked on clk, optionally held off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// check sampled on clk, disabled while rst_n is low
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on clk, active during reset as well
`define SLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLT_ASSERT(lbl, prop, msg)
`define SLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// shared constants and types of the sorted list table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slt_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 7;
  localparam int OUT_W   = 48;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch request, clear scan state
    logic step;    // issue next table read
    logic finish;  // tail write, update length
    logic emit;    // load result beat
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/slt_ctrl.sv =====
// ----------------------------------------------------------------------------
// slt_ctrl
// request sequencer: accept, scan the table, finish, hand off the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  slt_pkg::sts_t sts,
  output slt_pkg::cmd_t cmd
);
  import slt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        // no beat is taken while reset is held
        in_tready = rst_n;
        cmd.start = in_tvalid && rst_n;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_TAIL: begin
        cmd.finish = 1'b1;
      end
      ST_DONE: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/slt_datapath.sv =====
// ----------------------------------------------------------------------------
// slt_datapath
// entry memory, scan pipeline, insert shift, remove compaction, result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_list_table_macros.svh"

module slt_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slt_pkg::cmd_t                 cmd,
  output slt_pkg::sts_t                 sts,
  input  logic [slt_pkg::KIND_W-1:0]    req_kind,
  input  logic [slt_pkg::VAL_W-1:0]     req_value,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [slt_pkg::OUT_W-1:0]     out_tdata
);
  import slt_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  logic [KIND_W-1:0] kind_r,    kind_nxt;
  logic [VAL_W-1:0]  value_r,   value_nxt;
  logic              full_r,    full_nxt;
  logic [CW-1:0]     count_r,   count_nxt;
  logic [CW-1:0]     ra_r,      ra_nxt;
  logic              rv_r,      rv_nxt;
  logic [CW-1:0]     ridx_r,    ridx_nxt;
  logic [CW-1:0]     wr_r,      wr_nxt;
  logic              ins_r,     ins_nxt;
  logic [VAL_W-1:0]  carry_r,   carry_nxt;
  logic              found_r,   found_nxt;
  logic [VAL_W-1:0]  tail_r,    tail_nxt;
  logic [CW-1:0]     removed_r, removed_nxt;
  logic              ovalid_r,  ovalid_nxt;
  logic [OUT_W-1:0]  odata_r,   odata_nxt;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [VAL_W-1:0]  wd;
  logic              do_ins;
  logic              eq;

  assign do_ins = (kind_r == KIND_INSERT) && !full_r;
  assign eq     = (rdata_r == value_r);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_comb begin
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    full_nxt    = full_r;
    count_nxt   = count_r;
    ra_nxt      = ra_r;
    rv_nxt      = 1'b0;
    ridx_nxt    = ridx_r;
    wr_nxt      = wr_r;
    ins_nxt     = ins_r;
    carry_nxt   = carry_r;
    found_nxt   = found_r;
    tail_nxt    = tail_r;
    removed_nxt = removed_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    odata_nxt   = odata_r;
    rd_en       = 1'b0;
    rd_addr     = ra_r[AW-1:0];
    we          = 1'b0;
    wa          = ridx_r[AW-1:0];
    wd          = rdata_r;

    if (cmd.start) begin
      kind_nxt  = req_kind;
      value_nxt = req_value;
      full_nxt  = (req_kind == KIND_INSERT) && (count_r == CW'(DEPTH));
      ra_nxt    = '0;
      wr_nxt    = '0;
      ins_nxt   = 1'b0;
      found_nxt = 1'b0;
      tail_nxt  = '0;
    end

    if (cmd.step && (ra_r < count_r)) begin
      rd_en    = 1'b1;
      rv_nxt   = 1'b1;
      ridx_nxt = ra_r;
      ra_nxt   = ra_r + CW'(1);
    end

    // one stored entry arrives per cycle
    if (rv_r) begin
      if (eq) found_nxt = 1'b1;
      if (do_ins) begin
        if (ins_r) begin
          // ripple entries up by one behind the insertion point
          we        = 1'b1;
          wd        = carry_r;
          carry_nxt = rdata_r;
        end else if ($signed(value_r) <= $signed(rdata_r)) begin
          we        = 1'b1;
          wd        = value_r;
          carry_nxt = rdata_r;
          ins_nxt   = 1'b1;
        end
      end else if (kind_r == KIND_REMOVE) begin
        if (!eq) begin
          we       = 1'b1;
          wa       = wr_r[AW-1:0];
          wd       = rdata_r;
          wr_nxt   = wr_r + CW'(1);
          tail_nxt = rdata_r;
        end
      end else begin
        tail_nxt = rdata_r;
      end
    end

    if (cmd.finish) begin
      removed_nxt = '0;
      if (do_ins) begin
        we        = 1'b1;
        wa        = count_r[AW-1:0];
        wd        = ins_r ? carry_r : value_r;
        tail_nxt  = wd;
        count_nxt = count_r + CW'(1);
      end else if (kind_r == KIND_REMOVE) begin
        count_nxt   = wr_r;
        removed_nxt = count_r - wr_r;
      end
    end

    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {LEN_W'(removed_r), tail_r, LEN_W'(count_r), found_r, full_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rv_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rv_r     <= rv_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    value_r   <= value_nxt;
    full_r    <= full_nxt;
    ra_r      <= ra_nxt;
    ridx_r    <= ridx_nxt;
    wr_r      <= wr_nxt;
    ins_r     <= ins_nxt;
    carry_r   <= carry_nxt;
    found_r   <= found_nxt;
    tail_r    <= tail_nxt;
    removed_r <= removed_nxt;
    odata_r   <= odata_nxt;
  end

  assign sts.scan_done = (ra_r == count_r) && !rv_r;
  assign sts.out_free  = !ovalid_r || out_tready;
  assign out_tvalid    = ovalid_r;
  assign out_tdata     = odata_r;

  `SLT_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "entry count above table depth")
  `SLT_ASSERT(a_read_in_list, rv_r |-> ridx_r < count_r, "read beyond stored entries")
  `SLT_ASSERT(a_compact_behind, (rv_r && kind_r == KIND_REMOVE) |-> wr_r <= ridx_r,
              "compaction write ahead of read")
  `SLT_ASSERT(a_full_no_write, (rv_r && full_r) |-> !we, "dropped insert wrote the table")

endmodule

// ===== hdl/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table
// ascending list of signed 32-bit values with insert, remove-all and query
// ----------------------------------------------------------------------------
// usage:
//   one request beat on in_*: in_tuser is the kind (insert, remove all equal,
//   query; code 3 acts as a query) and in_tdata the value. each request gives
//   exactly one result beat on out_*.
//   the table is scanned one entry per cycle through a single-port-read memory;
//   an insert ripples the tail up by one, a remove compacts in the same pass.
//   the time from a request's accept to its out_tvalid grows with the number
//   of stored entries, since the scan of the stored entries sets it.
//   a new request is taken once the previous one has reached the result
//   register, even if out_tready is low; if the result register is still
//   occupied when the next one finishes, the block holds until it drains.
//   reset empties the list at once; stored entries need no clearing.
//   an insert into a full table is dropped and reported with status set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [slt_pkg::VAL_W-1:0]          in_tdata,   // [31:0] value
  input  logic [slt_pkg::KIND_W-1:0]         in_tuser,   // [1:0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] status, [1] found, [8:2] length, [40:9] last_value, [47:41] removed_count
  output logic [slt_pkg::OUT_W-1:0]          out_tdata
);
  import slt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_kind   (in_tuser),
    .req_value  (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
